// ===== sv/scpa_pkg.sv =====
// Shared types, codes and helpers for the size-class pool allocator.
// Used by scpa_layout and size_class_pool_allocator_unit; depends on nothing.
package scpa_pkg;

  localparam int BLOCKS_PER_CLASS_DEF = 8;
  localparam int NUM_CLASSES_DEF      = 3;
  localparam int HEADER_BYTES_DEF     = 8;

  // Classes that have a log2 register; any further class uses a fixed size.
  localparam int CFG_CLASSES = 3;

  localparam logic [3:0] LOG2_MIN = 4'd4;
  localparam logic [3:0] LOG2_MAX = 4'd12;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_AREA_BASE = 2'd0,
    REG_CLASS0    = 2'd1,
    REG_CLASS1    = 2'd2,
    REG_CLASS2    = 2'd3
  } reg_idx_t;

  function automatic logic [3:0] clamp_log2(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < LOG2_MIN) begin
      r = LOG2_MIN;
    end else if (v > LOG2_MAX) begin
      r = LOG2_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/scpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependencies; holds the per-class free stacks.
module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/scpa_layout.sv =====
// Configuration registers and the derived class layout (block size, region base).
// Depends on scpa_pkg. Region bases are rebuilt one class per cycle after a write.
module scpa_layout
  import scpa_pkg::*;
#(
  parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF,
  parameter int NUM_CLASSES      = NUM_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic [3:0]  lg   [NUM_CLASSES],
  output logic [31:0] base [NUM_CLASSES],
  output logic        settling
);

  localparam int SW = $clog2(NUM_CLASSES + 1);

  logic [31:0]   area_base_r;
  logic [3:0]    log2_r [CFG_CLASSES];
  logic [31:0]   base_r [NUM_CLASSES];
  logic [SW-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_base_r <= '0;
      log2_r[0]   <= 4'd4;
      log2_r[1]   <= 4'd5;
      log2_r[2]   <= 4'd6;
      settle_r    <= SW'(NUM_CLASSES);
    end else begin
      if (cfg_wr) begin
        settle_r <= SW'(NUM_CLASSES);
        case (reg_idx_t'(cfg_index))
          REG_AREA_BASE: area_base_r <= cfg_data;
          REG_CLASS0:    log2_r[0]   <= cfg_data[3:0];
          REG_CLASS1:    log2_r[1]   <= cfg_data[3:0];
          REG_CLASS2:    log2_r[2]   <= cfg_data[3:0];
          default:       area_base_r <= area_base_r;
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - SW'(1);
      end
    end
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    if (c < CFG_CLASSES) begin : g_reg
      assign lg[c] = clamp_log2(log2_r[c]);
    end else begin : g_fixed
      assign lg[c] = clamp_log2(4'(int'(LOG2_MIN) + c));
    end

    // Each base is the previous base plus the previous class's region span.
    if (c == 0) begin : g_first
      always_ff @(posedge clk) begin
        base_r[c] <= area_base_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        base_r[c] <= base_r[c-1] + (32'(BLOCKS_PER_CLASS) << lg[c-1]);
      end
    end

    assign base[c] = base_r[c];
  end

  assign settling = (settle_r != '0);

endmodule

// ===== sv/size_class_pool_allocator_unit.sv =====
// Top level of the size-class pool allocator: command decode, free-list counters,
// free-stack RAM and result register. Depends on scpa_pkg, scpa_layout, scpa_ram.
//
// Usage:
//   A request (in_cmd, in_req_bytes, in_mem_addr) is taken at a clock edge with
//   start high and busy low. Commands: init rebuilds every free list, allocate
//   pops the first class whose payload fits, free pushes a block back.
//   Every request gives exactly one result on out_payload_addr, out_status and
//   out_size_class, shown for one cycle with out_strobe high, after passing the
//   request register s1_r and then the output registers. The receiver
//   cannot stall; results are simply presented.
//   A new request can be taken every cycle while busy is low: the free stacks
//   live in one synchronous RAM, a pop reads it in the request cycle and the
//   returned block index forms the address in the following cycle.
//   Configuration writes (cfg_valid, cfg_index, cfg_data; cfg_ready is always
//   high) are made while no request is in flight. After each write, and after
//   reset, busy stays high while the region bases are rebuilt one class per
//   cycle.
//   Reset (rst_n low, synchronous) restores the register defaults and fills
//   every class with its blocks, block 0 handed out first. No clearing pass
//   over the RAM is needed: a per-class low mark tells which stack slots hold
//   their initial contents.
module size_class_pool_allocator_unit
  import scpa_pkg::*;
#(
  parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF,
  parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
  parameter int HEADER_BYTES     = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_req_bytes,
  input  logic [31:0] in_mem_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic [31:0] out_payload_addr,
  output logic [1:0]  out_status,
  output logic [1:0]  out_size_class
);

  localparam int CW    = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int PW    = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic           valid;
    logic           alloc;
    logic [1:0]     status;
    logic [CLW-1:0] cls;
    logic           dflt;
    logic [PW-1:0]  pos;
  } stage_t;

  logic [3:0]  lg   [NUM_CLASSES];
  logic [31:0] base [NUM_CLASSES];
  logic        settling;
  logic        accept;

  logic [CW-1:0] cnt_r  [NUM_CLASSES];
  logic [CW-1:0] cnt_nxt[NUM_CLASSES];
  // Lowest count reached since init; slots below it still hold init contents.
  logic [CW-1:0] mark_r  [NUM_CLASSES];
  logic [CW-1:0] mark_nxt[NUM_CLASSES];

  stage_t s1_r, s1_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_wdata, ram_rdata;

  logic [NUM_CLASSES-1:0] fits, hits;
  logic [31:0]            offs [NUM_CLASSES];
  logic [31:0]            blk_addr;

  logic [CLW-1:0] a_cls, f_cls;
  logic           a_any, f_any;
  logic [CW-1:0]  a_cnt, f_cnt;
  logic [31:0]    f_mask;

  logic [31:0] out_addr_nxt;
  logic [PW-1:0] blk;

  scpa_layout #(
    .BLOCKS_PER_CLASS(BLOCKS_PER_CLASS),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_layout (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lg       (lg),
    .base     (base),
    .settling (settling)
  );

  scpa_ram #(
    .WIDTH(PW),
    .DEPTH(DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy      = settling;
  assign accept    = start && !busy;
  assign blk_addr  = in_mem_addr - 32'(HEADER_BYTES);

  // Per-class checks run side by side; the lowest matching class wins.
  always_comb begin
    logic [31:0] bb;
    logic [31:0] pay;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      bb      = 32'd1 << lg[c];
      pay     = (bb > 32'(HEADER_BYTES)) ? bb - 32'(HEADER_BYTES) : 32'd0;
      fits[c] = ({16'd0, in_req_bytes} <= pay);
      offs[c] = blk_addr - base[c];
      hits[c] = (offs[c] < (32'(BLOCKS_PER_CLASS) << lg[c]));
    end
    a_cls = '0;
    f_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fits[c]) begin
        a_cls = CLW'(c);
      end
      if (hits[c]) begin
        f_cls = CLW'(c);
      end
    end
    a_any = |fits;
    f_any = |hits;
  end

  assign a_cnt  = cnt_r[a_cls];
  assign f_cnt  = cnt_r[f_cls];
  assign f_mask = (32'd1 << lg[f_cls]) - 32'd1;

  always_comb begin
    cnt_nxt   = cnt_r;
    mark_nxt  = mark_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'(int'(f_cls) * BLOCKS_PER_CLASS + int'(f_cnt));
    ram_wdata = PW'(offs[f_cls] >> lg[f_cls]);
    ram_raddr = AW'(int'(a_cls) * BLOCKS_PER_CLASS + int'(a_cnt) - 1);
    s1_nxt        = '0;
    s1_nxt.valid  = accept;
    s1_nxt.status = ST_OK;
    if (accept) begin
      case (cmd_t'(in_cmd))
        CMD_INIT: begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            cnt_nxt[c]  = CW'(BLOCKS_PER_CLASS);
            mark_nxt[c] = CW'(BLOCKS_PER_CLASS);
          end
        end
        CMD_ALLOC: begin
          if (!a_any) begin
            s1_nxt.status = ST_TOO_BIG;
          end else if (a_cnt == '0) begin
            s1_nxt.status = ST_EMPTY;
          end else begin
            ram_re         = 1'b1;
            s1_nxt.alloc   = 1'b1;
            s1_nxt.cls     = a_cls;
            s1_nxt.pos     = PW'(a_cnt - CW'(1));
            // A slot never pushed since init still holds its initial index.
            s1_nxt.dflt    = (a_cnt == mark_r[a_cls]);
            cnt_nxt[a_cls] = a_cnt - CW'(1);
            if (a_cnt == mark_r[a_cls]) begin
              mark_nxt[a_cls] = a_cnt - CW'(1);
            end
          end
        end
        CMD_FREE: begin
          if (f_any && ((offs[f_cls] & f_mask) == 32'd0)
              && (f_cnt < CW'(BLOCKS_PER_CLASS))) begin
            ram_we         = 1'b1;
            s1_nxt.cls     = f_cls;
            cnt_nxt[f_cls] = f_cnt + CW'(1);
          end else begin
            s1_nxt.status = ST_BAD_FREE;
          end
        end
        default: begin
          s1_nxt.status = ST_OK;
        end
      endcase
    end
  end

  assign blk = s1_r.dflt ? (PW'(BLOCKS_PER_CLASS - 1) - s1_r.pos) : ram_rdata;
  assign out_addr_nxt = s1_r.alloc
      ? base[s1_r.cls] + (32'(blk) << lg[s1_r.cls]) + 32'(HEADER_BYTES)
      : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c]  <= CW'(BLOCKS_PER_CLASS);
        mark_r[c] <= CW'(BLOCKS_PER_CLASS);
      end
      s1_r       <= '0;
      out_strobe <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      mark_r     <= mark_nxt;
      s1_r       <= s1_nxt;
      out_strobe <= s1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_payload_addr <= out_addr_nxt;
    out_status       <= s1_r.status;
    out_size_class   <= 2'(s1_r.cls);
  end

`ifndef SYNTHESIS
  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result strobe without a request two cycles earlier");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_payload_addr == 32'd0))
    else $error("failed request returned a nonzero address");

  a_cfg_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("request path open while the layout is rebuilding");

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_chk
    a_mark_le_count: assert property (@(posedge clk) disable iff (!rst_n)
      (mark_r[c] <= cnt_r[c]) && (cnt_r[c] <= CW'(BLOCKS_PER_CLASS)))
      else $error("free-list low mark or count out of order");
  end
`endif

endmodule
